/* sv/lhtm_pkg.sv */
// lhtm_pkg: item structs, event kinds, tier codes, register indexes and reset values
// for the link health tier monitor; no dependencies
package lhtm_pkg;

  localparam int RTT_W      = 16;
  localparam int SEQ_W      = 8;
  localparam int QBYTES_W   = 24;
  localparam int JIT_W      = 10;
  // square of a jitter threshold
  localparam int JSQ_W      = 2 * JIT_W;
  localparam int CNT32_W    = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [2:0] KIND_RTT        = 3'd0;
  localparam logic [2:0] KIND_SEQ        = 3'd1;
  localparam logic [2:0] KIND_BUF        = 3'd2;
  localparam logic [2:0] KIND_CONNECT    = 3'd3;
  localparam logic [2:0] KIND_DISCONNECT = 3'd4;
  localparam logic [2:0] KIND_TICK       = 3'd5;

  localparam logic [1:0] TIER_GREEN  = 2'd0;
  localparam logic [1:0] TIER_YELLOW = 2'd1;
  localparam logic [1:0] TIER_ORANGE = 2'd2;
  localparam logic [1:0] TIER_RED    = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_RTT_RED    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RTT_ORANGE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RTT_YELLOW = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_JIT_ORANGE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_JIT_YELLOW = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BUF_ORANGE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_BUF_YELLOW = 3'd6;

  localparam logic [RTT_W-1:0]    RST_RTT_RED    = 16'd200;
  localparam logic [RTT_W-1:0]    RST_RTT_ORANGE = 16'd100;
  localparam logic [RTT_W-1:0]    RST_RTT_YELLOW = 16'd50;
  localparam logic [JIT_W-1:0]    RST_JIT_ORANGE = 10'd50;
  localparam logic [JIT_W-1:0]    RST_JIT_YELLOW = 10'd20;
  localparam logic [QBYTES_W-1:0] RST_BUF_ORANGE = 24'd48000;
  localparam logic [QBYTES_W-1:0] RST_BUF_YELLOW = 24'd19200;

  typedef struct packed {
    logic [2:0]          kind;
    logic [RTT_W-1:0]    rtt_ms;
    logic [SEQ_W-1:0]    sequence_req;
    logic [QBYTES_W-1:0] queue_bytes;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         tier;
    logic               tier_changed;
    logic [CNT32_W-1:0] lost_interval;
    logic [CNT32_W-1:0] total_interval;
    logic [CNT32_W-1:0] lost_total;
    logic [CNT32_W-1:0] total_total;
  } out_item_t;

endpackage

/* sv/lhtm_ram.sv */
// lhtm_ram: generic single-write, single-read ram with registered read data
// no dependencies
module lhtm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/lhtm_mul.sv */
// lhtm_mul: shared unsigned multiplier with a registered, enabled product
// no dependencies
module lhtm_mul #(
  parameter int WIDTH = 20
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [WIDTH-1:0]   a_i,
  input  logic [WIDTH-1:0]   b_i,
  output logic [2*WIDTH-1:0] p_o
);

  logic [2*WIDTH-1:0] p_q;

  // product holds while not enabled, so a waiting step still sees it
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= {{WIDTH{1'b0}}, a_i} * {{WIDTH{1'b0}}, b_i};
    end
  end

  assign p_o = p_q;

endmodule

/* sv/link_health_tier_monitor_core.sv */
// path from accept to the result register: sequence, buffer, connect, disconnect, idle tick
// and unused kinds load it from exec, an rtt sample goes through exec, r1 and r2, a tick while
// connected through exec and t1 to t8; one item at a time, taken only in idle; a tick runs
// eight products through the one shared multiplier (n^2, n*sumsq in two halves, sum^2, two
// thresholds squared and scaled by n^2); a stalled result waits in its final state
// async active-low reset: defaults in config, tier red, counters clear, window ram not cleared
module link_health_tier_monitor_core #(
  parameter int RTT_WINDOW_DEPTH = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  lhtm_pkg::in_item_t                    in_item_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output lhtm_pkg::out_item_t                   out_item_o,
  input  logic                                  cfg_we_i,
  input  logic [lhtm_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [lhtm_pkg::CFG_DATA_W-1:0]       cfg_wdata_i
);

  import lhtm_pkg::*;

  localparam int LOG_D  = $clog2(RTT_WINDOW_DEPTH);
  localparam int IDX_W  = (RTT_WINDOW_DEPTH > 1) ? LOG_D : 1;
  localparam int CNT_W  = $clog2(RTT_WINDOW_DEPTH + 1);
  localparam int SUM_W  = RTT_W + LOG_D;
  localparam int SQ_W   = 2 * RTT_W + LOG_D;
  localparam int MUL_W  = (SUM_W > JSQ_W) ? SUM_W : JSQ_W;
  localparam int PROD_W = 2 * MUL_W;
  localparam int LHS_W  = CNT_W + SQ_W;
  localparam int WIDE_W = (LHS_W > PROD_W) ? LHS_W : PROD_W;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_EXEC = 4'd1;
  localparam logic [3:0] S_R1   = 4'd2;
  localparam logic [3:0] S_R2   = 4'd3;
  localparam logic [3:0] S_T1   = 4'd4;
  localparam logic [3:0] S_T2   = 4'd5;
  localparam logic [3:0] S_T3   = 4'd6;
  localparam logic [3:0] S_T4   = 4'd7;
  localparam logic [3:0] S_T5   = 4'd8;
  localparam logic [3:0] S_T6   = 4'd9;
  localparam logic [3:0] S_T7   = 4'd10;
  localparam logic [3:0] S_T8   = 4'd11;

  function automatic logic [1:0] tier_max(logic [1:0] a, logic [1:0] b);
    return (a > b) ? a : b;
  endfunction

  function automatic logic [CNT32_W-1:0] sat_add(logic [CNT32_W-1:0] a,
                                                 logic [CNT32_W-1:0] b);
    logic [CNT32_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CNT32_W] ? {CNT32_W{1'b1}} : s[CNT32_W-1:0];
  endfunction

  // config registers
  logic [RTT_W-1:0]    rtt_red_q, rtt_orange_q, rtt_yellow_q;
  logic [JIT_W-1:0]    jit_orange_q, jit_yellow_q;
  logic [QBYTES_W-1:0] buf_orange_q, buf_yellow_q;

  // control and monitor state
  logic [3:0]          state_q, state_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [IDX_W-1:0]    head_q, head_d;
  logic [SUM_W-1:0]    sum_q, sum_d;
  logic [SQ_W-1:0]     sq_q, sq_d;
  logic                have_q, have_d;
  logic [RTT_W-1:0]    latest_q, latest_d;
  logic [SEQ_W-1:0]    prev_seq_q, prev_seq_d;
  logic                prev_valid_q, prev_valid_d;
  logic [CNT32_W-1:0]  lost_int_q, lost_int_d;
  logic [CNT32_W-1:0]  rcv_int_q, rcv_int_d;
  logic [CNT32_W-1:0]  lost_tot_q, lost_tot_d;
  logic [CNT32_W-1:0]  rcv_tot_q, rcv_tot_d;
  logic [QBYTES_W-1:0] buf_q, buf_d;
  logic                link_up_q, link_up_d;
  logic                seen_q, seen_d;
  logic                was_seen_q, was_seen_d;
  logic [1:0]          stale_q, stale_d;
  logic [1:0]          tier_q, tier_d;
  logic                out_valid_q, out_valid_d;

  // payload registers
  in_item_t            item_q;
  out_item_t           out_q, out_d;
  logic [2*RTT_W-1:0]  vv_q;
  logic [2*CNT_W-1:0]  n2_q;
  logic [WIDE_W-1:0]   lhs_q;
  logic [WIDE_W-1:0]   spread_q;
  logic                jo_hit_q;

  // datapath wires
  logic                in_accept;
  logic                out_free;
  logic                out_load;
  logic                changed;
  logic                tick_clear;
  logic                full;
  logic [SEQ_W-1:0]    gap;
  logic                jy_hit;
  logic [1:0]          rated_tier;
  logic                mul_en;
  logic [MUL_W-1:0]    mul_a, mul_b;
  logic [PROD_W-1:0]   prod;
  logic                ram_we;
  logic [RTT_W-1:0]    ram_rdata;
  logic [WIDE_W-1:0]   prod_wide;

  assign in_accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;
  assign full = (count_q == CNT_W'(RTT_WINDOW_DEPTH));
  assign gap = item_q.sequence_req - (prev_seq_q + SEQ_W'(1));
  assign prod_wide = WIDE_W'(prod);
  assign jy_hit = (spread_q > prod_wide);

  lhtm_mul #(
    .WIDTH (MUL_W)
  ) u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  lhtm_ram #(
    .WIDTH (RTT_W),
    .DEPTH (RTT_WINDOW_DEPTH)
  ) u_window (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (head_q),
    .wdata_i (item_q.rtt_ms),
    .raddr_i (head_q),
    .rdata_o (ram_rdata)
  );

  // health rating for a tick
  always_comb begin
    rated_tier = TIER_GREEN;
    if (have_q) begin
      if (latest_q > rtt_red_q) begin
        rated_tier = TIER_RED;
      end else if (latest_q > rtt_orange_q) begin
        rated_tier = TIER_ORANGE;
      end else if (latest_q > rtt_yellow_q) begin
        rated_tier = TIER_YELLOW;
      end
    end
    if (jo_hit_q) begin
      rated_tier = tier_max(rated_tier, TIER_ORANGE);
    end else if (jy_hit) begin
      rated_tier = tier_max(rated_tier, TIER_YELLOW);
    end
    if (buf_q > buf_orange_q) begin
      rated_tier = tier_max(rated_tier, TIER_ORANGE);
    end else if (buf_q > buf_yellow_q) begin
      rated_tier = tier_max(rated_tier, TIER_YELLOW);
    end
    if (was_seen_q && !seen_q) begin
      rated_tier = tier_max(rated_tier, TIER_ORANGE);
    end
    if (stale_q >= 2'd2) begin
      rated_tier = TIER_RED;
    end else if (stale_q >= 2'd1) begin
      rated_tier = tier_max(rated_tier, TIER_ORANGE);
    end
  end

  // sequencer and state update
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    head_d       = head_q;
    sum_d        = sum_q;
    sq_d         = sq_q;
    have_d       = have_q;
    latest_d     = latest_q;
    prev_seq_d   = prev_seq_q;
    prev_valid_d = prev_valid_q;
    lost_int_d   = lost_int_q;
    rcv_int_d    = rcv_int_q;
    lost_tot_d   = lost_tot_q;
    rcv_tot_d    = rcv_tot_q;
    buf_d        = buf_q;
    link_up_d    = link_up_q;
    seen_d       = seen_q;
    was_seen_d   = was_seen_q;
    stale_d      = stale_q;
    tier_d       = tier_q;
    changed      = 1'b0;
    tick_clear   = 1'b0;
    out_load     = 1'b0;
    mul_en       = 1'b0;
    mul_a        = '0;
    mul_b        = '0;
    ram_we       = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (item_q.kind == KIND_RTT) begin
          mul_en  = 1'b1;
          mul_a   = MUL_W'(item_q.rtt_ms);
          mul_b   = MUL_W'(item_q.rtt_ms);
          state_d = S_R1;
        end else if (item_q.kind == KIND_TICK && link_up_q) begin
          mul_en  = 1'b1;
          mul_a   = MUL_W'(count_q);
          mul_b   = MUL_W'(count_q);
          state_d = S_T1;
        end else if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
          case (item_q.kind)
            KIND_SEQ: begin
              rcv_int_d = sat_add(rcv_int_q, CNT32_W'(1));
              rcv_tot_d = sat_add(rcv_tot_q, CNT32_W'(1));
              seen_d    = 1'b1;
              // forward gap of 1 to 127 counts as loss
              if (prev_valid_q && gap != '0 && !gap[SEQ_W-1]) begin
                lost_int_d = sat_add(lost_int_q, CNT32_W'(gap));
                lost_tot_d = sat_add(lost_tot_q, CNT32_W'(gap));
              end
              prev_seq_d   = item_q.sequence_req;
              prev_valid_d = 1'b1;
            end
            KIND_BUF: begin
              buf_d = item_q.queue_bytes;
            end
            KIND_CONNECT: begin
              link_up_d    = 1'b1;
              count_d      = '0;
              head_d       = '0;
              sum_d        = '0;
              sq_d         = '0;
              have_d       = 1'b0;
              latest_d     = '0;
              prev_valid_d = 1'b0;
              lost_int_d   = '0;
              rcv_int_d    = '0;
              lost_tot_d   = '0;
              rcv_tot_d    = '0;
              seen_d       = 1'b0;
              was_seen_d   = 1'b0;
              stale_d      = '0;
              tier_d       = TIER_GREEN;
              changed      = 1'b1;
            end
            KIND_DISCONNECT: begin
              link_up_d = 1'b0;
              seen_d    = 1'b0;
              have_d    = 1'b0;
              latest_d  = '0;
              tier_d    = TIER_RED;
              changed   = 1'b1;
            end
            default: begin
              // tick while down and unused kinds leave state alone
            end
          endcase
        end
      end
      S_R1: begin
        // ram read data holds the entry at the head
        mul_en  = 1'b1;
        mul_a   = MUL_W'(ram_rdata);
        mul_b   = MUL_W'(ram_rdata);
        state_d = S_R2;
      end
      S_R2: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
          ram_we   = 1'b1;
          sum_d    = sum_q + SUM_W'(item_q.rtt_ms) - (full ? SUM_W'(ram_rdata) : '0);
          sq_d     = sq_q + SQ_W'(vv_q) - (full ? SQ_W'(prod) : '0);
          count_d  = full ? count_q : count_q + CNT_W'(1);
          head_d   = (head_q == IDX_W'(RTT_WINDOW_DEPTH - 1)) ? '0 : head_q + IDX_W'(1);
          latest_d = item_q.rtt_ms;
          have_d   = 1'b1;
          stale_d  = '0;
        end
      end
      S_T1: begin
        mul_en  = 1'b1;
        mul_a   = MUL_W'(count_q);
        mul_b   = MUL_W'(sq_q[MUL_W-1:0]);
        state_d = S_T2;
      end
      S_T2: begin
        mul_en  = 1'b1;
        mul_a   = MUL_W'(count_q);
        mul_b   = MUL_W'(sq_q[SQ_W-1:MUL_W]);
        state_d = S_T3;
      end
      S_T3: begin
        mul_en  = 1'b1;
        mul_a   = MUL_W'(sum_q);
        mul_b   = MUL_W'(sum_q);
        state_d = S_T4;
      end
      S_T4: begin
        mul_en  = 1'b1;
        mul_a   = MUL_W'(jit_orange_q);
        mul_b   = MUL_W'(jit_orange_q);
        state_d = S_T5;
      end
      S_T5: begin
        mul_en  = 1'b1;
        mul_a   = MUL_W'(prod[JSQ_W-1:0]);
        mul_b   = MUL_W'(n2_q);
        state_d = S_T6;
      end
      S_T6: begin
        mul_en  = 1'b1;
        mul_a   = MUL_W'(jit_yellow_q);
        mul_b   = MUL_W'(jit_yellow_q);
        state_d = S_T7;
      end
      S_T7: begin
        mul_en  = 1'b1;
        mul_a   = MUL_W'(prod[JSQ_W-1:0]);
        mul_b   = MUL_W'(n2_q);
        state_d = S_T8;
      end
      S_T8: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_d    = S_IDLE;
          tick_clear = 1'b1;
          tier_d     = rated_tier;
          changed    = (rated_tier != tier_q);
          stale_d    = (stale_q >= 2'd2) ? stale_q : stale_q + 2'd1;
          lost_int_d = '0;
          rcv_int_d  = '0;
          was_seen_d = was_seen_q | seen_q;
          seen_d     = 1'b0;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    out_d.tier           = tier_d;
    out_d.tier_changed   = changed;
    // a tick reports the interval counts from before clearing
    out_d.lost_interval  = tick_clear ? lost_int_q : lost_int_d;
    out_d.total_interval = tick_clear ? rcv_int_q : rcv_int_d;
    out_d.lost_total     = lost_tot_d;
    out_d.total_total    = rcv_tot_d;

    out_valid_d = out_valid_q && out_stall_i;
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rtt_red_q    <= RST_RTT_RED;
      rtt_orange_q <= RST_RTT_ORANGE;
      rtt_yellow_q <= RST_RTT_YELLOW;
      jit_orange_q <= RST_JIT_ORANGE;
      jit_yellow_q <= RST_JIT_YELLOW;
      buf_orange_q <= RST_BUF_ORANGE;
      buf_yellow_q <= RST_BUF_YELLOW;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_RTT_RED:    rtt_red_q    <= cfg_wdata_i[RTT_W-1:0];
        CFG_RTT_ORANGE: rtt_orange_q <= cfg_wdata_i[RTT_W-1:0];
        CFG_RTT_YELLOW: rtt_yellow_q <= cfg_wdata_i[RTT_W-1:0];
        CFG_JIT_ORANGE: jit_orange_q <= cfg_wdata_i[JIT_W-1:0];
        CFG_JIT_YELLOW: jit_yellow_q <= cfg_wdata_i[JIT_W-1:0];
        CFG_BUF_ORANGE: buf_orange_q <= cfg_wdata_i[QBYTES_W-1:0];
        CFG_BUF_YELLOW: buf_yellow_q <= cfg_wdata_i[QBYTES_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      head_q       <= '0;
      sum_q        <= '0;
      sq_q         <= '0;
      have_q       <= 1'b0;
      latest_q     <= '0;
      prev_seq_q   <= '0;
      prev_valid_q <= 1'b0;
      lost_int_q   <= '0;
      rcv_int_q    <= '0;
      lost_tot_q   <= '0;
      rcv_tot_q    <= '0;
      buf_q        <= '0;
      link_up_q    <= 1'b0;
      seen_q       <= 1'b0;
      was_seen_q   <= 1'b0;
      stale_q      <= '0;
      tier_q       <= TIER_RED;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      head_q       <= head_d;
      sum_q        <= sum_d;
      sq_q         <= sq_d;
      have_q       <= have_d;
      latest_q     <= latest_d;
      prev_seq_q   <= prev_seq_d;
      prev_valid_q <= prev_valid_d;
      lost_int_q   <= lost_int_d;
      rcv_int_q    <= rcv_int_d;
      lost_tot_q   <= lost_tot_d;
      rcv_tot_q    <= rcv_tot_d;
      buf_q        <= buf_d;
      link_up_q    <= link_up_d;
      seen_q       <= seen_d;
      was_seen_q   <= was_seen_d;
      stale_q      <= stale_d;
      tier_q       <= tier_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // payload and jitter working registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q <= in_item_i;
    end
    if (out_load) begin
      out_q <= out_d;
    end
    case (state_q)
      S_R1: vv_q <= prod[2*RTT_W-1:0];
      S_T1: n2_q <= prod[2*CNT_W-1:0];
      S_T2: lhs_q <= prod_wide;
      S_T3: lhs_q <= lhs_q + (prod_wide << MUL_W);
      S_T4: spread_q <= (lhs_q > prod_wide) ? lhs_q - prod_wide : '0;
      S_T6: jo_hit_q <= (spread_q > prod_wide);
      default: begin
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

/* sv/lhtm_checker.sv */
// lhtm_checker: port-level assertions for the link health tier monitor, bound to the top
// depends on lhtm_pkg and link_health_tier_monitor_core
module lhtm_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input lhtm_pkg::in_item_t  in_item_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input lhtm_pkg::out_item_t out_item_o
);

  import lhtm_pkg::*;

  logic in_accept;
  assign in_accept = in_valid_i && !in_stall_o;

  // a waiting result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed while stalled");

  // one item at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> in_stall_o)
    else $error("input taken while an item is at work");

  a_connect_green: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && in_item_i.kind == KIND_CONNECT && !out_valid_o |=> ##1
      out_valid_o && out_item_o.tier == TIER_GREEN && out_item_o.tier_changed)
    else $error("connect did not give a green change notice");

  a_disconnect_red: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && in_item_i.kind == KIND_DISCONNECT && !out_valid_o |=> ##1
      out_valid_o && out_item_o.tier == TIER_RED && out_item_o.tier_changed)
    else $error("disconnect did not give a red change notice");

  // interval counts never pass the counts since connect
  a_interval_le_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.lost_interval <= out_item_o.lost_total &&
      out_item_o.total_interval <= out_item_o.total_total)
    else $error("interval count above total count");

endmodule

bind link_health_tier_monitor_core lhtm_checker u_lhtm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_item_i   (in_item_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);

/* bench/link_health_tier_monitor_core_tb.sv */
// link_health_tier_monitor_core_tb: self-checking bench for the link health tier monitor,
// directed event table then random phases under several threshold settings
// depends on lhtm_pkg and link_health_tier_monitor_core only
module link_health_tier_monitor_core_tb;
  import lhtm_pkg::*;

  localparam int WIN_DEPTH     = 16;
  localparam int N_REGS        = 7;
  localparam int N_PHASES      = 10;
  localparam int PHASE_EVENTS  = 115;
  localparam int DIRECTED_ROWS = 25;
  localparam int DRAIN_CYCLES  = 20;
  localparam int RING_DEPTH    = 16;

  localparam logic [2:0] KIND_SPARE_A = 3'd6;
  localparam logic [2:0] KIND_SPARE_B = 3'd7;

  typedef struct packed {
    in_item_t  ev;
    logic      typed;
    out_item_t want;
  } plan_row_t;

  localparam out_item_t WANT_NONE = '0;
  localparam out_item_t WANT_DOWN = '{TIER_RED, 1'b0, 32'd0, 32'd0, 32'd0, 32'd0};
  localparam out_item_t WANT_UP   = '{TIER_GREEN, 1'b1, 32'd0, 32'd0, 32'd0, 32'd0};

  localparam plan_row_t PLAN [DIRECTED_ROWS] = '{
    // tick and spare kinds while down change nothing
    '{'{KIND_TICK, 16'd0, 8'd0, 24'd0}, 1'b1, WANT_DOWN},
    '{'{KIND_SPARE_A, 16'hFFFF, 8'hFF, 24'hFFFFFF}, 1'b1, WANT_DOWN},
    '{'{KIND_SPARE_B, 16'd0, 8'd0, 24'd0}, 1'b1, WANT_DOWN},
    '{'{KIND_SEQ, 16'd0, 8'd5, 24'd0}, 1'b1, '{TIER_RED, 1'b0, 32'd0, 32'd1, 32'd0, 32'd1}},
    // buffer level survives the connect
    '{'{KIND_BUF, 16'd0, 8'd0, 24'd20000}, 1'b0, WANT_NONE},
    '{'{KIND_CONNECT, 16'd0, 8'd0, 24'd0}, 1'b1, WANT_UP},
    '{'{KIND_TICK, 16'd0, 8'd0, 24'd0}, 1'b1,
      '{TIER_YELLOW, 1'b1, 32'd0, 32'd0, 32'd0, 32'd0}},
    // stale pings: one then two then saturated
    '{'{KIND_TICK, 16'd0, 8'd0, 24'd0}, 1'b1,
      '{TIER_ORANGE, 1'b1, 32'd0, 32'd0, 32'd0, 32'd0}},
    '{'{KIND_TICK, 16'd0, 8'd0, 24'd0}, 1'b1,
      '{TIER_RED, 1'b1, 32'd0, 32'd0, 32'd0, 32'd0}},
    '{'{KIND_TICK, 16'd0, 8'd0, 24'd0}, 1'b1, WANT_DOWN},
    '{'{KIND_RTT, 16'd0, 8'd0, 24'd0}, 1'b0, WANT_NONE},
    '{'{KIND_RTT, 16'hFFFF, 8'd0, 24'd0}, 1'b0, WANT_NONE},
    '{'{KIND_SEQ, 16'd0, 8'd0, 24'd0}, 1'b0, WANT_NONE},
    // backward step, wrap, largest counted gap, duplicate, gap of 128
    '{'{KIND_SEQ, 16'd0, 8'd255, 24'd0}, 1'b0, WANT_NONE},
    '{'{KIND_SEQ, 16'd0, 8'd0, 24'd0}, 1'b0, WANT_NONE},
    '{'{KIND_SEQ, 16'd0, 8'd128, 24'd0}, 1'b0, WANT_NONE},
    '{'{KIND_SEQ, 16'd0, 8'd128, 24'd0}, 1'b0, WANT_NONE},
    '{'{KIND_SEQ, 16'd0, 8'd1, 24'd0}, 1'b0, WANT_NONE},
    '{'{KIND_BUF, 16'd0, 8'd0, 24'hFFFFFF}, 1'b0, WANT_NONE},
    '{'{KIND_TICK, 16'd0, 8'd0, 24'd0}, 1'b0, WANT_NONE},
    '{'{KIND_BUF, 16'd0, 8'd0, 24'd0}, 1'b0, WANT_NONE},
    '{'{KIND_RTT, 16'd60, 8'd0, 24'd0}, 1'b0, WANT_NONE},
    // audio heard last interval but not this one
    '{'{KIND_TICK, 16'd0, 8'd0, 24'd0}, 1'b0, WANT_NONE},
    '{'{KIND_DISCONNECT, 16'd0, 8'd0, 24'd0}, 1'b0, WANT_NONE},
    '{'{KIND_CONNECT, 16'hFFFF, 8'hFF, 24'hFFFFFF}, 1'b1, WANT_UP}
  };

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_item = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_item;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  link_health_tier_monitor_core #(
    .RTT_WINDOW_DEPTH(WIN_DEPTH)
  ) u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_wdata_i(cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // thresholds as the block should hold them
  logic [RTT_W-1:0]    thr_rtt_red    = RST_RTT_RED;
  logic [RTT_W-1:0]    thr_rtt_orange = RST_RTT_ORANGE;
  logic [RTT_W-1:0]    thr_rtt_yellow = RST_RTT_YELLOW;
  logic [JIT_W-1:0]    thr_jit_orange = RST_JIT_ORANGE;
  logic [JIT_W-1:0]    thr_jit_yellow = RST_JIT_YELLOW;
  logic [QBYTES_W-1:0] thr_buf_orange = RST_BUF_ORANGE;
  logic [QBYTES_W-1:0] thr_buf_yellow = RST_BUF_YELLOW;

  // link state as the block should hold it
  logic [RTT_W-1:0]    win_mem [WIN_DEPTH];
  int                  win_fill = 0;
  int                  win_ptr = 0;
  bit [63:0]           win_sum = '0;
  bit [63:0]           win_sq = '0;
  bit                  have_rtt = 1'b0;
  logic [RTT_W-1:0]    last_rtt = '0;
  logic [SEQ_W-1:0]    last_seq = '0;
  bit                  last_seq_ok = 1'b0;
  logic [31:0]         lost_ivl = '0;
  logic [31:0]         rcvd_ivl = '0;
  logic [31:0]         lost_conn = '0;
  logic [31:0]         rcvd_conn = '0;
  logic [QBYTES_W-1:0] buf_lvl = '0;
  bit                  is_up = 1'b0;
  bit                  heard_audio = 1'b0;
  bit                  heard_before = 1'b0;
  int                  missed_polls = 0;
  logic [1:0]          tier_now = TIER_RED;

  // expected results in order, written at accept and read at result
  out_item_t expect_ring [RING_DEPTH];
  int        ring_wr = 0;
  int        ring_rd = 0;

  // stimulus shaping, redrawn on each tick
  int         rtt_base = 40;
  int         rtt_spread = 8;
  bit         mute_audio = 1'b0;
  bit         mute_rtt = 1'b0;
  logic [7:0] gen_seq = '0;
  bit         idle_on = 1'b1;
  bit         stall_on = 1'b1;
  int         stall_run = 0;

  int errors = 0;
  int events_sent = 0;
  int results_checked = 0;
  int settings_done = 0;
  int ticks_rated = 0;
  int tier_flips = 0;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic logic [1:0] lift(input logic [1:0] t, input logic [1:0] floor_t);
    return (t > floor_t) ? t : floor_t;
  endfunction

  // std dev above thr, without the root: n*sumsq - sum^2 > thr^2 * n^2
  function automatic bit spread_exceeds(input logic [JIT_W-1:0] thr);
    bit [63:0] n, lhs, sq, spread, lim;
    n = 64'(win_fill);
    lhs = n * win_sq;
    sq = win_sum * win_sum;
    spread = (lhs > sq) ? lhs - sq : 64'd0;
    lim = 64'(thr) * 64'(thr) * n * n;
    return spread > lim;
  endfunction

  function automatic logic [1:0] grade_link();
    logic [1:0] t;
    t = TIER_GREEN;
    if (have_rtt) begin
      if (last_rtt > thr_rtt_red) t = TIER_RED;
      else if (last_rtt > thr_rtt_orange) t = TIER_ORANGE;
      else if (last_rtt > thr_rtt_yellow) t = TIER_YELLOW;
    end
    if (spread_exceeds(thr_jit_orange)) t = lift(t, TIER_ORANGE);
    else if (spread_exceeds(thr_jit_yellow)) t = lift(t, TIER_YELLOW);
    if (buf_lvl > thr_buf_orange) t = lift(t, TIER_ORANGE);
    else if (buf_lvl > thr_buf_yellow) t = lift(t, TIER_YELLOW);
    if (heard_before && !heard_audio) t = lift(t, TIER_ORANGE);
    if (missed_polls >= 2) t = lift(t, TIER_RED);
    else if (missed_polls >= 1) t = lift(t, TIER_ORANGE);
    return t;
  endfunction

  task automatic advance_link_state(input in_item_t ev, output out_item_t res);
    logic [RTT_W-1:0] evicted;
    logic [7:0]       gap;
    logic [1:0]       rated;
    logic             flip;
    logic [31:0]      rep_lost, rep_rcvd;
    flip = 1'b0;
    case (ev.kind)
      KIND_RTT: begin
        last_rtt = ev.rtt_ms;
        have_rtt = 1'b1;
        missed_polls = 0;
        if (win_fill >= WIN_DEPTH) begin
          evicted = win_mem[win_ptr];
          win_sum = win_sum - 64'(evicted);
          win_sq = win_sq - 64'(evicted) * 64'(evicted);
        end else begin
          win_fill++;
        end
        win_mem[win_ptr] = ev.rtt_ms;
        win_sum = win_sum + 64'(ev.rtt_ms);
        win_sq = win_sq + 64'(ev.rtt_ms) * 64'(ev.rtt_ms);
        win_ptr = (win_ptr + 1) % WIN_DEPTH;
      end
      KIND_SEQ: begin
        rcvd_ivl = sat_add(rcvd_ivl, 32'd1);
        rcvd_conn = sat_add(rcvd_conn, 32'd1);
        heard_audio = 1'b1;
        if (last_seq_ok) begin
          gap = ev.sequence_req - (last_seq + 8'd1);
          if (gap != 8'd0 && gap < 8'd128) begin
            lost_ivl = sat_add(lost_ivl, 32'(gap));
            lost_conn = sat_add(lost_conn, 32'(gap));
          end
        end
        last_seq = ev.sequence_req;
        last_seq_ok = 1'b1;
      end
      KIND_BUF: buf_lvl = ev.queue_bytes;
      KIND_CONNECT: begin
        is_up = 1'b1;
        win_fill = 0;
        win_ptr = 0;
        win_sum = '0;
        win_sq = '0;
        have_rtt = 1'b0;
        last_rtt = '0;
        last_seq_ok = 1'b0;
        lost_ivl = '0;
        rcvd_ivl = '0;
        lost_conn = '0;
        rcvd_conn = '0;
        heard_audio = 1'b0;
        heard_before = 1'b0;
        missed_polls = 0;
        tier_now = TIER_GREEN;
        flip = 1'b1;
      end
      KIND_DISCONNECT: begin
        is_up = 1'b0;
        heard_audio = 1'b0;
        have_rtt = 1'b0;
        last_rtt = '0;
        tier_now = TIER_RED;
        flip = 1'b1;
      end
      default: ;
    endcase
    rep_lost = lost_ivl;
    rep_rcvd = rcvd_ivl;
    if (ev.kind == KIND_TICK && is_up) begin
      rated = grade_link();
      ticks_rated++;
      if (rated != tier_now) begin
        tier_now = rated;
        flip = 1'b1;
      end
      if (missed_polls < 2) missed_polls++;
      lost_ivl = '0;
      rcvd_ivl = '0;
      if (heard_audio) heard_before = 1'b1;
      heard_audio = 1'b0;
    end
    if (flip) tier_flips++;
    res.tier = tier_now;
    res.tier_changed = flip;
    res.lost_interval = rep_lost;
    res.total_interval = rep_rcvd;
    res.lost_total = lost_conn;
    res.total_total = rcvd_conn;
  endtask

  function automatic in_item_t make_event();
    in_item_t ev;
    int       r, s;
    ev.kind = KIND_RTT;
    ev.rtt_ms = 16'($urandom);
    ev.sequence_req = 8'($urandom);
    ev.queue_bytes = 24'($urandom);
    r = $urandom_range(0, 99);
    if (!is_up && $urandom_range(0, 3) == 0) ev.kind = KIND_CONNECT;
    else if (r < 32) ev.kind = mute_rtt ? KIND_BUF : KIND_RTT;
    else if (r < 62) ev.kind = mute_audio ? KIND_RTT : KIND_SEQ;
    else if (r < 72) ev.kind = KIND_BUF;
    else if (r < 90) ev.kind = KIND_TICK;
    else if (r < 93) ev.kind = KIND_DISCONNECT;
    else if (r < 95) ev.kind = KIND_CONNECT;
    else if (r < 97) ev.kind = r[0] ? KIND_SPARE_A : KIND_SPARE_B;
    // the top few percent keep a fully random rtt
    if (r < 97) begin
      case (ev.kind)
        KIND_RTT:
          if ($urandom_range(0, 4) != 0) ev.rtt_ms = 16'(rtt_base + $urandom_range(0, rtt_spread));
        KIND_SEQ: begin
          s = $urandom_range(0, 9);
          if (s < 7) ev.sequence_req = gen_seq + 8'd1;
          else if (s < 9) ev.sequence_req = gen_seq + 8'($urandom_range(2, 140));
          gen_seq = ev.sequence_req;
        end
        KIND_BUF:
          if ($urandom_range(0, 4) < 3) ev.queue_bytes = 24'($urandom_range(0, 70000));
        KIND_TICK: begin
          mute_audio = ($urandom_range(0, 4) == 0);
          mute_rtt = ($urandom_range(0, 4) == 0);
          rtt_base = $urandom_range(0, 300);
          case ($urandom_range(0, 3))
            0: rtt_spread = 0;
            1: rtt_spread = 8;
            2: rtt_spread = 30;
            default: rtt_spread = 120;
          endcase
        end
        default: ;
      endcase
    end
    return ev;
  endfunction

  task automatic send_event(input in_item_t ev, input bit typed, input out_item_t want);
    out_item_t predicted;
    in_valid <= 1'b1;
    in_item <= ev;
    do @(posedge clk); while (in_stall);
    advance_link_state(ev, predicted);
    expect_ring[ring_wr % RING_DEPTH] = typed ? want : predicted;
    ring_wr++;
    events_sent++;
  endtask

  task automatic pause_input();
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  task automatic drain();
    while (ring_wr != ring_rd) @(posedge clk);
  endtask

  task automatic program_thresholds(input logic [23:0] red, orange, yellow, jor, jye, bor, bye);
    logic [CFG_DATA_W-1:0] vals [N_REGS];
    vals[CFG_RTT_RED] = red;
    vals[CFG_RTT_ORANGE] = orange;
    vals[CFG_RTT_YELLOW] = yellow;
    vals[CFG_JIT_ORANGE] = jor;
    vals[CFG_JIT_YELLOW] = jye;
    vals[CFG_BUF_ORANGE] = bor;
    vals[CFG_BUF_YELLOW] = bye;
    for (int i = 0; i < N_REGS; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_wdata <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    thr_rtt_red = red[RTT_W-1:0];
    thr_rtt_orange = orange[RTT_W-1:0];
    thr_rtt_yellow = yellow[RTT_W-1:0];
    thr_jit_orange = jor[JIT_W-1:0];
    thr_jit_yellow = jye[JIT_W-1:0];
    thr_buf_orange = bor;
    thr_buf_yellow = bye;
    settings_done++;
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endtask

  // result stall in bursts
  always @(posedge clk) begin
    if (!stall_on) begin
      out_stall <= 1'b0;
    end else if (stall_run > 0) begin
      out_stall <= 1'b1;
      stall_run = stall_run - 1;
    end else if ($urandom_range(0, 7) == 0) begin
      out_stall <= 1'b1;
      stall_run = $urandom_range(1, 13) - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (ring_wr == ring_rd) begin
        $error("result with nothing pending: %p", out_item);
        errors++;
      end else begin
        want = expect_ring[ring_rd % RING_DEPTH];
        ring_rd++;
        check_field("tier", 32'(want.tier), 32'(out_item.tier));
        check_field("tier_changed", 32'(want.tier_changed), 32'(out_item.tier_changed));
        check_field("lost_interval", want.lost_interval, out_item.lost_interval);
        check_field("total_interval", want.total_interval, out_item.total_interval);
        check_field("lost_total", want.lost_total, out_item.lost_total);
        check_field("total_total", want.total_total, out_item.total_total);
        results_checked++;
      end
    end
  end

  initial begin
    #20_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    in_item_t ev;
    int       sent;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      pause_input();
      send_event(PLAN[r].ev, PLAN[r].typed, PLAN[r].want);
    end

    for (int p = 0; p < N_PHASES; p++) begin
      in_valid <= 1'b0;
      drain();
      // last phase runs with no gaps on either side
      idle_on = (p % 3 != 1) && (p != N_PHASES - 1);
      stall_on = (p % 3 != 2) && (p != N_PHASES - 1);
      case (p)
        0: program_thresholds('0, '0, '0, '0, '0, '0, '0);
        1: program_thresholds('1, '1, '1, '1, '1, '1, '1);
        2: program_thresholds(24'(RST_RTT_RED), 24'(RST_RTT_ORANGE), 24'(RST_RTT_YELLOW),
                              24'(RST_JIT_ORANGE), 24'(RST_JIT_YELLOW),
                              RST_BUF_ORANGE, RST_BUF_YELLOW);
        default:
          if ($urandom_range(0, 3) == 0) begin
            program_thresholds(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                               24'($urandom), 24'($urandom), 24'($urandom));
          end else begin
            program_thresholds(24'($urandom_range(0, 500)), 24'($urandom_range(0, 300)),
                               24'($urandom_range(0, 200)), 24'($urandom_range(0, 200)),
                               24'($urandom_range(0, 80)), 24'($urandom_range(0, 70000)),
                               24'($urandom_range(0, 40000)));
          end
      endcase
      sent = 0;
      while (sent < PHASE_EVENTS) begin
        ev = make_event();
        pause_input();
        send_event(ev, 1'b0, WANT_NONE);
        if (ev.kind != KIND_SPARE_A && ev.kind != KIND_SPARE_B) sent++;
      end
    end

    in_valid <= 1'b0;
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d items (%0d directed), %0d results checked, %0d threshold sets",
             events_sent, DIRECTED_ROWS, results_checked, settings_done);
    $display("%0d ticks rated while connected, %0d tier-change notices",
             ticks_rated, tier_flips);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
